// ===== sv/life_automaton_grid_assert.svh =====
// Assertion macros shared by the grid RTL.
// They expect signals named clk and arst_n in the enclosing module.
`ifndef LIFE_AUTOMATON_GRID_ASSERT_SVH
`define LIFE_AUTOMATON_GRID_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LIFEG_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LIFEG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/lifeg_pkg.sv =====
`timescale 1ns / 1ps

package lifeg_pkg;

	// Grid capacity.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W = $clog2(MAX_ROWS);
	localparam int COL_W = $clog2(MAX_COLS);
	// Clamped sizes must be able to hold the maximum itself.
	localparam int NR_W = ROW_W + 1;
	localparam int NC_W = COL_W + 1;

	// Configuration port.
	localparam int CFG_W = 7;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_USED_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_USED_COLS = 2'd1;
	localparam logic [CFG_W-1:0] CFG_ROWS_RESET = 7'd64;
	localparam logic [CFG_W-1:0] CFG_COLS_RESET = 7'd64;

	// Operation codes.
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_STEP  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// One request.
	typedef struct packed {
		op_t        op;
		logic [5:0] row;
		logic [5:0] col;
		logic       cell_value;
	} cmd_t;

	// One result.
	typedef struct packed {
		logic cell_alive;
		logic status;
	} rsp_t;

	// Access to the row memory in a given cycle.
	typedef struct packed {
		logic                rd_en;
		logic [ROW_W-1:0]    raddr;
		logic                wr_en;
		logic [ROW_W-1:0]    waddr;
		logic [MAX_COLS-1:0] wdata;
	} mem_req_t;

	typedef logic [MAX_COLS-1:0] row_vec_t;

	// A size of zero acts as one, a size above the capacity acts as the capacity.
	function automatic logic [NR_W-1:0] clamp_rows(logic [CFG_W-1:0] v);
		logic [NR_W-1:0] r;
		if (v == '0) begin
			r = NR_W'(1);
		end else if (32'(v) > MAX_ROWS) begin
			r = NR_W'(MAX_ROWS);
		end else begin
			r = NR_W'(v);
		end
		return r;
	endfunction

	function automatic logic [NC_W-1:0] clamp_cols(logic [CFG_W-1:0] v);
		logic [NC_W-1:0] r;
		if (v == '0) begin
			r = NC_W'(1);
		end else if (32'(v) > MAX_COLS) begin
			r = NC_W'(MAX_COLS);
		end else begin
			r = NC_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== sv/lifeg_row_mem.sv =====
`timescale 1ns / 1ps

// Grid storage: one memory word per grid row, with a valid bit per row so
// that rows never written since reset read as all dead.
module lifeg_row_mem (
	input  logic                clk,
	input  logic                arst_n,
	input  lifeg_pkg::mem_req_t mreq,
	output lifeg_pkg::row_vec_t rd_row
);

	logic [lifeg_pkg::MAX_COLS-1:0] mem [lifeg_pkg::MAX_ROWS];
	logic [lifeg_pkg::MAX_COLS-1:0] rdata_q;
	logic [lifeg_pkg::MAX_ROWS-1:0] row_valid_q;
	logic                           rvalid_q;

	// Synchronous memory, one write port and one read port.
	always_ff @(posedge clk) begin
		if (mreq.wr_en) begin
			mem[mreq.waddr] <= mreq.wdata;
		end
		if (mreq.rd_en) begin
			rdata_q <= mem[mreq.raddr];
		end
	end

	// Row valid bits are cleared at once by reset and set by the first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (mreq.wr_en) begin
				row_valid_q[mreq.waddr] <= 1'b1;
			end
			if (mreq.rd_en) begin
				rvalid_q <= row_valid_q[mreq.raddr];
			end
		end
	end

	// A row that was never written reads as all dead.
	assign rd_row = rvalid_q ? rdata_q : '0;

endmodule

// ===== sv/lifeg_rule.sv =====
`timescale 1ns / 1ps

// Next value of one whole grid row under the B3/S23 rule. Columns outside
// the used width count as dead neighbors and keep their old value.
module lifeg_rule (
	input  lifeg_pkg::row_vec_t above,
	input  lifeg_pkg::row_vec_t cur,
	input  lifeg_pkg::row_vec_t below,
	input  lifeg_pkg::row_vec_t col_mask,
	output lifeg_pkg::row_vec_t next_row
);

	localparam int W = lifeg_pkg::MAX_COLS;

	logic [W+1:0] ap;
	logic [W+1:0] cp;
	logic [W+1:0] bp;

	// Pad each row with a dead cell on both sides.
	assign ap = {1'b0, above & col_mask, 1'b0};
	assign cp = {1'b0, cur & col_mask, 1'b0};
	assign bp = {1'b0, below & col_mask, 1'b0};

	// Count the eight neighbors of each cell and apply the rule.
	always_comb begin
		logic [3:0] n;
		logic       alive;
		next_row = cur;
		for (int c = 0; c < W; c++) begin
			n = 4'(ap[c]) + 4'(ap[c+1]) + 4'(ap[c+2])
				+ 4'(cp[c]) + 4'(cp[c+2])
				+ 4'(bp[c]) + 4'(bp[c+1]) + 4'(bp[c+2]);
			alive = cur[c] ? (n == 4'd2 || n == 4'd3) : (n == 4'd3);
			next_row[c] = col_mask[c] ? alive : cur[c];
		end
	end

endmodule

// ===== sv/life_automaton_grid.sv =====
`timescale 1ns / 1ps
`include "life_automaton_grid_assert.svh"

// Game of Life grid (rule B3/S23, dead borders, no wraparound). A request is
// taken when start is high and busy is low; its single result appears on rsp
// with done high for exactly one cycle and must be captured then, since the
// block cannot be held off. A cell write or read reads its row when taken and
// answers from ST_CELL; an out-of-range access or unknown op answers in the
// cycle after the request. A generation step goes through ST_LOAD and then
// ST_RD and ST_CALC once for each row in use (used_rows with 0 taken as 1 and
// anything above 64 taken as 64): the grid is stored one row per memory word,
// and each row needs one memory read and one write-back through the single
// row memory. busy stays high until the last row is written. No clearing pass
// is needed after reset.
// Configuration writes are meant only while no request is in progress.
module life_automaton_grid (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  lifeg_pkg::cmd_t                     cmd,
	output logic                                done,
	output lifeg_pkg::rsp_t                     rsp,
	input  logic                                cfg_we,
	input  logic [lifeg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lifeg_pkg::CFG_W-1:0]         cfg_wdata
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_CELL = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_RD   = 5'b01000,
		ST_CALC = 5'b10000
	} state_t;

	state_t                            state_q;
	logic [lifeg_pkg::CFG_W-1:0]       used_rows_q;
	logic [lifeg_pkg::CFG_W-1:0]       used_cols_q;
	lifeg_pkg::cmd_t                   cmd_q;
	logic [lifeg_pkg::ROW_W-1:0]       row_q;
	lifeg_pkg::row_vec_t               above_q;
	lifeg_pkg::row_vec_t               cur_q;
	logic                              done_q;
	lifeg_pkg::rsp_t                   rsp_q;

	logic [lifeg_pkg::NR_W-1:0]        nr;
	logic [lifeg_pkg::NC_W-1:0]        nc;
	lifeg_pkg::row_vec_t               col_mask;
	lifeg_pkg::row_vec_t               rd_row;
	lifeg_pkg::row_vec_t               below;
	lifeg_pkg::row_vec_t               next_row;
	lifeg_pkg::row_vec_t               cell_row;
	lifeg_pkg::mem_req_t               mem_req;
	logic                              accept;
	logic                              in_range;
	logic                              row_last;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign done = done_q;
	assign rsp = rsp_q;

	// Effective grid size.
	assign nr = lifeg_pkg::clamp_rows(used_rows_q);
	assign nc = lifeg_pkg::clamp_cols(used_cols_q);

	always_comb begin
		for (int c = 0; c < lifeg_pkg::MAX_COLS; c++) begin
			col_mask[c] = (c < 32'(nc));
		end
	end

	assign in_range = (32'(cmd.row) < 32'(nr)) && (32'(cmd.col) < 32'(nc));
	assign row_last = ((lifeg_pkg::NR_W'(row_q) + lifeg_pkg::NR_W'(1)) == nr);
	assign below = row_last ? '0 : rd_row;

	// Row read with the addressed cell replaced, for a cell write.
	always_comb begin
		cell_row = rd_row;
		cell_row[lifeg_pkg::COL_W'(cmd_q.col)] = cmd_q.cell_value;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_rows_q <= lifeg_pkg::CFG_ROWS_RESET;
			used_cols_q <= lifeg_pkg::CFG_COLS_RESET;
		end else if (cfg_we) begin
			if (cfg_index == lifeg_pkg::CFG_USED_ROWS) begin
				used_rows_q <= cfg_wdata;
			end else if (cfg_index == lifeg_pkg::CFG_USED_COLS) begin
				used_cols_q <= cfg_wdata;
			end
		end
	end

	// Memory access for the current cycle.
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if ((cmd.op == lifeg_pkg::OP_WRITE || cmd.op == lifeg_pkg::OP_READ)
						&& in_range) begin
						mem_req.rd_en = 1'b1;
						mem_req.raddr = lifeg_pkg::ROW_W'(cmd.row);
					end else if (cmd.op == lifeg_pkg::OP_STEP) begin
						mem_req.rd_en = 1'b1;
						mem_req.raddr = '0;
					end
				end
			end
			ST_CELL: begin
				if (cmd_q.op == lifeg_pkg::OP_WRITE) begin
					mem_req.wr_en = 1'b1;
					mem_req.waddr = lifeg_pkg::ROW_W'(cmd_q.row);
					mem_req.wdata = cell_row;
				end
			end
			ST_LOAD: begin
			end
			ST_RD: begin
				if (!row_last) begin
					mem_req.rd_en = 1'b1;
					mem_req.raddr = row_q + lifeg_pkg::ROW_W'(1);
				end
			end
			ST_CALC: begin
				mem_req.wr_en = 1'b1;
				mem_req.waddr = row_q;
				mem_req.wdata = next_row;
			end
			default: begin
			end
		endcase
	end

	// Request sequencing and the generation walk.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q <= 1'b0;
			row_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (cmd.op == lifeg_pkg::OP_WRITE || cmd.op == lifeg_pkg::OP_READ) begin
							if (in_range) begin
								state_q <= ST_CELL;
							end else begin
								done_q <= 1'b1;
							end
						end else if (cmd.op == lifeg_pkg::OP_STEP) begin
							state_q <= ST_LOAD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				ST_CELL: begin
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LOAD: begin
					row_q <= '0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (row_last) begin
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						row_q <= row_q + lifeg_pkg::ROW_W'(1);
						state_q <= ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: request copy, old-row buffers and the result.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			rsp_q.cell_alive <= 1'b0;
			rsp_q.status <= (cmd.op == lifeg_pkg::OP_WRITE || cmd.op == lifeg_pkg::OP_READ)
				&& !in_range;
		end
		if (state_q == ST_CELL) begin
			rsp_q.cell_alive <= (cmd_q.op == lifeg_pkg::OP_READ)
				&& rd_row[lifeg_pkg::COL_W'(cmd_q.col)];
			rsp_q.status <= 1'b0;
		end
		if (state_q == ST_LOAD) begin
			above_q <= '0;
			cur_q <= rd_row;
		end
		if (state_q == ST_CALC) begin
			above_q <= cur_q;
			cur_q <= below;
			rsp_q.cell_alive <= 1'b0;
			rsp_q.status <= 1'b0;
		end
	end

	lifeg_row_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.mreq   (mem_req),
		.rd_row (rd_row)
	);

	lifeg_rule u_rule (
		.above    (above_q),
		.cur      (cur_q),
		.below    (below),
		.col_mask (col_mask),
		.next_row (next_row)
	);

	// The walk never reads and writes the row memory in the same cycle.
	`LIFEG_ASSERT_SAME(a_no_rw_overlap, mem_req.wr_en, !mem_req.rd_en, "row memory read and write overlap")
	// Writes come only from a cell write or a generation row write-back.
	`LIFEG_ASSERT_SAME(a_write_source, mem_req.wr_en, state_q == ST_CELL || state_q == ST_CALC, "row memory written outside a work state")
	// A result is shown only once the sequencer is back at rest.
	`LIFEG_ASSERT_SAME(a_done_at_rest, done_q, state_q == ST_IDLE, "result strobe while still working")
	// Every accepted request either answers at once or starts working.
	`LIFEG_ASSERT_NEXT(a_accept_moves, accept, done_q || busy, "accepted request was dropped")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import lifeg_pkg::*;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 100;
	localparam int CALM_TAIL = 30;

	// Keeps a private copy of the grid and the used size, and predicts the
	// result of every accepted request.
	class grid_scoreboard;
		row_vec_t cells [MAX_ROWS];
		logic [CFG_W-1:0] rows_reg;
		logic [CFG_W-1:0] cols_reg;
		rsp_t pending_rsp [$];
		int errors;
		int checked;
		int generations;

		function new();
			foreach (cells[r]) begin
				cells[r] = '0;
			end
			rows_reg = CFG_ROWS_RESET;
			cols_reg = CFG_COLS_RESET;
			errors = 0;
			checked = 0;
			generations = 0;
		endfunction

		// Zero behaves as one, anything above the capacity as the capacity.
		function int used_size(logic [CFG_W-1:0] v, int cap);
			if (v == 0) begin
				return 1;
			end
			if (int'(v) > cap) begin
				return cap;
			end
			return int'(v);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
			if (idx == CFG_USED_ROWS) begin
				rows_reg = v;
			end else if (idx == CFG_USED_COLS) begin
				cols_reg = v;
			end
		endfunction

		// One B3/S23 generation over the used area. Cells outside the used
		// area are neither changed nor counted as neighbors.
		function void next_generation();
			row_vec_t old_cells [MAX_ROWS];
			int nr, nc, live, r, c, dr, dc;
			nr = used_size(rows_reg, MAX_ROWS);
			nc = used_size(cols_reg, MAX_COLS);
			old_cells = cells;
			for (r = 0; r < nr; r++) begin
				for (c = 0; c < nc; c++) begin
					live = 0;
					for (dr = -1; dr <= 1; dr++) begin
						for (dc = -1; dc <= 1; dc++) begin
							if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < nr &&
									c + dc >= 0 && c + dc < nc) begin
								live += int'(old_cells[r + dr][c + dc]);
							end
						end
					end
					if (old_cells[r][c]) begin
						cells[r][c] = (live == 2 || live == 3);
					end else begin
						cells[r][c] = (live == 3);
					end
				end
			end
			generations++;
		endfunction

		function void note_request(cmd_t req);
			rsp_t want;
			int nr, nc;
			want = '0;
			nr = used_size(rows_reg, MAX_ROWS);
			nc = used_size(cols_reg, MAX_COLS);
			case (req.op)
				OP_WRITE, OP_READ: begin
					if (int'(req.row) >= nr || int'(req.col) >= nc) begin
						want.status = 1'b1;
					end else if (req.op == OP_WRITE) begin
						cells[req.row][req.col] = req.cell_value;
					end else begin
						want.cell_alive = cells[req.row][req.col];
					end
				end
				OP_STEP: begin
					next_generation();
				end
				default: begin
				end
			endcase
			pending_rsp.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result: cell_alive %b status %b",
					$time, got.cell_alive, got.status);
				errors++;
				return;
			end
			want = pending_rsp.pop_front();
			checked++;
			if (got.cell_alive !== want.cell_alive) begin
				$display("%0t: cell_alive expected %b actual %b",
					$time, want.cell_alive, got.cell_alive);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0t: status expected %b actual %b",
					$time, want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	cmd_t cmd;
	logic done;
	rsp_t rsp;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	grid_scoreboard sb;
	int cycle_count = 0;
	int random_items = 0;
	int size_settings = 0;
	bit calm = 1'b0;

	life_automaton_grid DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Watchdog on the whole run.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles.", cycle_count);
		$display("life_automaton_grid: mismatch");
		$finish;
	end

	// Observe accepted requests and results on the edge that takes them.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				sb.note_request(cmd);
			end
			if (done === 1'b1) begin
				sb.check_result(rsp);
			end
		end
	end

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Hold the request until the block takes it.
	task automatic issue(op_t op, int r, int c, bit v);
		cmd_t req;
		req.op = op;
		req.row = 6'(r);
		req.col = 6'(c);
		req.cell_value = v;
		if (!calm && $urandom_range(0, 3) == 0) begin
			pause($urandom_range(1, 4));
		end
		start <= 1'b1;
		cmd <= req;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// Stop sending and wait for every outstanding result and for busy to drop.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending_rsp.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// One register write; cfg_we is then dropped again.
	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Mostly small grids, with the extremes and out-of-range values mixed in.
	function automatic logic [CFG_W-1:0] pick_size();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'd127;
			2: return 7'd64;
			3: return 7'($urandom_range(65, 126));
			4: return 7'd1;
			5: return 7'($urandom_range(11, 63));
			default: return 7'($urandom_range(2, 10));
		endcase
	endfunction

	// One size setting: seed a small window with random cells, then mix
	// generation steps with reads of that window, plus some noise.
	task automatic random_phase();
		logic [CFG_W-1:0] rows_v, cols_v;
		int nr, nc, wr, wc, r0, c0, length, kind, k;
		drain();
		rows_v = pick_size();
		cols_v = pick_size();
		write_cfg(CFG_USED_ROWS, rows_v);
		write_cfg(CFG_USED_COLS, cols_v);
		if ($urandom_range(0, 3) == 0) begin
			write_cfg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, 7'($urandom));
		end
		size_settings++;
		nr = sb.used_size(rows_v, MAX_ROWS);
		nc = sb.used_size(cols_v, MAX_COLS);
		wr = (nr < 6) ? nr : $urandom_range(3, 6);
		wc = (nc < 6) ? nc : $urandom_range(3, 6);
		r0 = $urandom_range(0, nr - wr);
		c0 = $urandom_range(0, nc - wc);
		length = $urandom_range(20, 40);
		for (k = 0; k < length; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 8) begin
				issue(op_t'($urandom_range(0, 3)), $urandom_range(0, 63),
					$urandom_range(0, 63), $urandom_range(0, 1));
			end else begin
				if (k < length * 2 / 5) begin
					issue(OP_WRITE, r0 + $urandom_range(0, wr - 1),
						c0 + $urandom_range(0, wc - 1), $urandom_range(0, 1));
				end else if (kind < 25) begin
					issue(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 1));
				end else begin
					issue(OP_READ, r0 + $urandom_range(0, wr - 1),
						c0 + $urandom_range(0, wc - 1), $urandom_range(0, 1));
				end
			end
			random_items++;
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full grid after reset: a blinker on the top border and three cells
		// in the far corner that complete a block.
		issue(OP_WRITE, 0, 0, 1'b1);
		issue(OP_WRITE, 0, 1, 1'b1);
		issue(OP_WRITE, 0, 2, 1'b1);
		issue(OP_WRITE, 63, 62, 1'b1);
		issue(OP_WRITE, 63, 63, 1'b1);
		issue(OP_WRITE, 62, 63, 1'b1);
		issue(OP_READ, 63, 63, 1'b0);
		issue(OP_NONE, 63, 63, 1'b1);
		issue(OP_STEP, 0, 0, 1'b0);
		issue(OP_READ, 1, 1, 1'b0);
		issue(OP_READ, 0, 0, 1'b0);
		issue(OP_READ, 62, 62, 1'b0);

		// One row: zero rows behaves as one, too many columns as the maximum.
		drain();
		write_cfg(CFG_USED_ROWS, 7'd0);
		write_cfg(CFG_USED_COLS, 7'd127);
		write_cfg(CFG_SPARE_B, 7'd1);
		size_settings++;
		issue(OP_READ, 1, 0, 1'b0);
		issue(OP_WRITE, 5, 3, 1'b1);
		issue(OP_WRITE, 0, 0, 1'b1);
		issue(OP_WRITE, 0, 2, 1'b1);
		issue(OP_STEP, 0, 0, 1'b0);
		issue(OP_READ, 0, 1, 1'b0);
		issue(OP_READ, 0, 63, 1'b0);

		// One column.
		drain();
		write_cfg(CFG_USED_ROWS, 7'd127);
		write_cfg(CFG_USED_COLS, 7'd0);
		size_settings++;
		issue(OP_READ, 0, 1, 1'b0);
		issue(OP_READ, 63, 0, 1'b0);
		issue(OP_STEP, 0, 0, 1'b0);

		// Back to the full grid: cells outside the narrow sizes kept their values.
		drain();
		write_cfg(CFG_USED_ROWS, 7'd64);
		write_cfg(CFG_USED_COLS, 7'd64);
		size_settings++;
		issue(OP_READ, 1, 1, 1'b0);
		issue(OP_READ, 62, 62, 1'b0);

		while (random_items < RANDOM_ITEMS) begin
			calm = (random_items >= RANDOM_ITEMS - CALM_TAIL);
			random_phase();
		end

		drain();
		repeat (8) @(posedge clk);
		$display("Ran %0d random requests over %0d grid size settings, %0d generations.",
			random_items, size_settings, sb.generations);
		$display("Compared %0d results, %0d field errors.", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending_rsp.size() == 0) begin
			$display("life_automaton_grid: match");
		end else begin
			$display("life_automaton_grid: mismatch");
		end
		$finish;
	end

endmodule
